/* rtl/core/xtea_block_decipher_macros.svh */
// Assertion macros shared by the XTEA block decipher RTL.
`ifndef XTEA_BLOCK_DECIPHER_MACROS_SVH
`define XTEA_BLOCK_DECIPHER_MACROS_SVH

// Checks that a condition in one cycle is followed by a consequence in the next cycle.
`define XBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define XBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/xbd_pkg.sv */
// Types and constants shared by the XTEA block decipher pipeline.
package xbd_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [1:0]        key_idx_t;

    localparam int    KEY_COUNT = 4;
    localparam word_t XBD_DELTA = 32'h9E37_79B9;

    // Configuration register indexes.
    localparam key_idx_t KEY_WORD_0 = 2'd0;
    localparam key_idx_t KEY_WORD_1 = 2'd1;
    localparam key_idx_t KEY_WORD_2 = 2'd2;
    localparam key_idx_t KEY_WORD_3 = 2'd3;

endpackage

/* rtl/core/xbd_half_round.sv */
// One pipeline stage of the XTEA decipher: a single half-round with a fixed sum.
module xbd_half_round #(
    parameter logic [31:0] SUM      = 32'h0000_0000,
    parameter bit          UPDATE_Y = 1'b0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  xbd_pkg::word_t in_y,
    input  xbd_pkg::word_t in_z,
    input  xbd_pkg::word_t key_word,
    output logic          out_valid,
    output xbd_pkg::word_t out_y,
    output xbd_pkg::word_t out_z
);
    import xbd_pkg::*;

    logic  valid_reg;
    word_t y_reg;
    word_t z_reg;
    word_t src;
    word_t dst;
    word_t mix;
    word_t round_key;
    word_t dst_next;

    // The word that feeds the mix function and the word that is updated.
    assign src = UPDATE_Y ? in_z : in_y;
    assign dst = UPDATE_Y ? in_y : in_z;

    // Mix, key addition and subtraction of one half-round.
    assign mix       = ((src << 4) ^ (src >> 5)) + src;
    assign round_key = SUM + key_word;
    assign dst_next  = dst - (mix ^ round_key);

    // Valid bit travels with the item and holds during a stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload registers load only when the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= UPDATE_Y ? dst_next : in_y;
            z_reg <= UPDATE_Y ? in_z : dst_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

/* rtl/core/xtea_block_decipher.sv */
// XTEA block decipher top level: key registers and the half-round pipeline.
//
// Deciphers one 64-bit XTEA block per clock cycle while the pipeline is not
// stalled. Each of the 2*ROUND_COUNT pipeline stages performs one half-round
// (one mix add, an exclusive-or with the key-plus-sum word, and one
// subtraction). An item accepted on cipher passes through the stage registers
// in order and is presented on plain from the last stage. The round sums are
// fixed per stage, so no sum register runs with the data. The whole pipeline
// advances together: it holds while a result on plain is not taken, and
// cipher_ready follows plain_ready in that case. The four key words are to be
// written through the cfg port while no item is in flight; the block itself
// does not enforce this. The key words are reset to zero.
module xtea_block_decipher #(
    parameter int ROUND_COUNT = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  xbd_pkg::key_idx_t cfg_index,
    input  xbd_pkg::word_t    cfg_data,
    input  logic              cipher_valid,
    output logic              cipher_ready,
    input  xbd_pkg::word_t    cipher_first,
    input  xbd_pkg::word_t    cipher_second,
    output logic              plain_valid,
    input  logic              plain_ready,
    output xbd_pkg::word_t    plain_first,
    output xbd_pkg::word_t    plain_second
);
    import xbd_pkg::*;

    `include "xtea_block_decipher_macros.svh"

    localparam int STAGES = 2 * ROUND_COUNT;

    word_t            key_reg [KEY_COUNT];
    logic             adv;
    logic [STAGES-1:0] valid_vec;
    word_t            stage_y [STAGES];
    word_t            stage_z [STAGES];

    // Key register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                KEY_WORD_0: key_reg[0] <= cfg_data;
                KEY_WORD_1: key_reg[1] <= cfg_data;
                KEY_WORD_2: key_reg[2] <= cfg_data;
                KEY_WORD_3: key_reg[3] <= cfg_data;
                default:    key_reg[0] <= key_reg[0];
            endcase
        end
    end

    // The pipeline moves whenever the output stage is empty or being emptied.
    assign adv          = !valid_vec[STAGES-1] || plain_ready;
    assign cipher_ready = adv;

    // Half-round stages; even stages update z, odd stages update y.
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        localparam int          ROUND_LEFT = ROUND_COUNT - s / 2 - s % 2;
        localparam logic [63:0] PROD       = 64'(XBD_DELTA) * 64'(ROUND_LEFT);
        localparam logic [31:0] SUM_S      = PROD[31:0];
        localparam key_idx_t    KEY_SEL    = (s % 2 == 0) ? SUM_S[12:11] : SUM_S[1:0];

        logic  in_v;
        word_t in_y;
        word_t in_z;

        if (s == 0)
        begin : g_head
            assign in_v = cipher_valid;
            assign in_y = cipher_first;
            assign in_z = cipher_second;
        end
        else
        begin : g_body
            assign in_v = valid_vec[s-1];
            assign in_y = stage_y[s-1];
            assign in_z = stage_z[s-1];
        end

        xbd_half_round #(
            .SUM      (SUM_S),
            .UPDATE_Y (s % 2 == 1)
        ) u_half_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (in_v),
            .in_y      (in_y),
            .in_z      (in_z),
            .key_word  (key_reg[KEY_SEL]),
            .out_valid (valid_vec[s]),
            .out_y     (stage_y[s]),
            .out_z     (stage_z[s])
        );
    end

    // Result from the last stage.
    assign plain_valid  = valid_vec[STAGES-1];
    assign plain_first  = stage_y[STAGES-1];
    assign plain_second = stage_z[STAGES-1];

    // A stall freezes the occupancy of every stage.
    `XBD_ASSERT_NEXT(a_stall_holds, !adv, $stable(valid_vec), "stalled pipeline changed occupancy")

    // An advance shifts every valid bit one stage on.
    `XBD_ASSERT_NEXT(a_adv_shifts, adv,
        valid_vec[STAGES-1:1] == $past(valid_vec[STAGES-2:0]), "valid bits lost in advance")

    // An accepted item occupies the first stage in the next cycle.
    `XBD_ASSERT_NEXT(a_accept_enters, cipher_valid && cipher_ready, valid_vec[0],
        "accepted item did not enter the pipeline")

endmodule
